// ===== hdl/sps_pkg.sv =====
package sps_pkg;

  localparam int unsigned SpeedW    = 8;
  localparam int unsigned StepCntW  = 16;
  localparam int unsigned WaveW     = 16;
  localparam logic [WaveW-1:0] WaveHalfStepsRst = 16'd200;

  typedef enum logic [1:0] {
    FIN_NONE = 2'd0,
    FIN_BOOT = 2'd1,
    FIN_MOVE = 2'd2
  } fin_e;

  typedef enum logic {
    KIND_TICK  = 1'b0,
    KIND_START = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e                kind;
    logic [SpeedW-1:0]    speed;
    logic [StepCntW-1:0]  step_count;
    logic                 continuous;
  } item_t;

  typedef struct packed {
    logic step_level;
    logic dir_level;
    fin_e finished;
    logic running;
  } result_t;

endpackage

// ===== hdl/sps_in_stage.sv =====
module sps_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  sps_pkg::item_t item_i,
  input  logic          take_i,
  output logic          valid_o,
  output sps_pkg::item_t item_o
);

  logic           valid_q, valid_d;
  sps_pkg::item_t item_q;

  // Free a slot when empty or when the held transaction moves on this cycle.
  assign ready_o = !valid_q || take_i;
  assign valid_d = (valid_i && ready_o) || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== hdl/sps_core.sv =====
module sps_core #(
  parameter int unsigned CntW = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sps_pkg::WaveW-1:0]           cfg_wdata_i,
  input  sps_pkg::item_t                      item_i,
  input  logic                                advance_i,
  output sps_pkg::result_t                    result_o
);

  logic [sps_pkg::WaveW-1:0]  wave_q;
  logic                       boot_q, boot_d;
  logic                       active_q, active_d;
  logic                       step_q, step_d;
  logic                       dir_q, dir_d;
  logic [CntW-1:0]            toggle_q, toggle_d;
  logic [CntW-1:0]            toggle_inc;
  logic [sps_pkg::SpeedW-1:0] div_q, div_d;
  logic [sps_pkg::SpeedW-1:0] div_inc;
  logic [sps_pkg::SpeedW-1:0] speed_q, speed_d;
  logic [CntW-1:0]            target_q, target_d;
  logic                       cont_q, cont_d;
  sps_pkg::fin_e              fin;

  assign toggle_inc = toggle_q + CntW'(1);
  assign div_inc    = div_q + sps_pkg::SpeedW'(1);

  always_comb begin
    boot_d   = boot_q;
    active_d = active_q;
    step_d   = step_q;
    dir_d    = dir_q;
    toggle_d = toggle_q;
    div_d    = div_q;
    speed_d  = speed_q;
    target_d = target_q;
    cont_d   = cont_q;
    fin      = sps_pkg::FIN_NONE;
    if (item_i.kind == sps_pkg::KIND_START) begin
      speed_d  = item_i.speed;
      target_d = CntW'(item_i.step_count);
      cont_d   = item_i.continuous;
      active_d = 1'b1;
    end else if (active_q) begin
      if (boot_q) begin
        step_d = !step_q;
        if (toggle_inc != CntW'(wave_q)) begin
          toggle_d = toggle_inc;
        end else begin
          toggle_d = '0;
          if (!dir_q) begin
            dir_d = 1'b1;
          end else begin
            // end of power-on wave
            boot_d   = 1'b0;
            active_d = 1'b0;
            speed_d  = sps_pkg::SpeedW'(1);
            fin      = sps_pkg::FIN_BOOT;
          end
        end
      end else if (speed_q == '0) begin
        active_d = 1'b0;
      end else if (div_inc != speed_q) begin
        div_d = div_inc;
      end else begin
        div_d  = '0;
        step_d = !step_q;
        if (!cont_q) begin
          if (toggle_inc != target_q) begin
            toggle_d = toggle_inc;
          end else begin
            toggle_d = '0;
            active_d = 1'b0;
            fin      = sps_pkg::FIN_MOVE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q   <= sps_pkg::WaveHalfStepsRst;
      boot_q   <= 1'b1;
      active_q <= 1'b1;
      step_q   <= 1'b0;
      dir_q    <= 1'b0;
      toggle_q <= '0;
      div_q    <= '0;
      speed_q  <= '0;
      target_q <= '0;
      cont_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        wave_q <= cfg_wdata_i;
      end
      if (advance_i) begin
        boot_q   <= boot_d;
        active_q <= active_d;
        step_q   <= step_d;
        dir_q    <= dir_d;
        toggle_q <= toggle_d;
        div_q    <= div_d;
        speed_q  <= speed_d;
        target_q <= target_d;
        cont_q   <= cont_d;
      end
    end
  end

  always_comb begin
    result_o.step_level = step_d;
    result_o.dir_level  = dir_d;
    result_o.finished   = fin;
    result_o.running    = active_d;
  end

endmodule

// ===== hdl/sps_out_stage.sv =====
module sps_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  sps_pkg::result_t result_i,
  output logic             valid_o,
  input  logic             ready_i,
  output sps_pkg::result_t result_o
);

  logic             valid_q;
  sps_pkg::result_t result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ===== hdl/stepper_step_pulse_sequencer.sv =====
// Channel  | Handshake               | Payload
// ---------+-------------------------+---------------------------------------------
// in       | in_valid_i / in_ready_o | kind_i, speed_i, step_count_i, continuous_i
// out      | out_valid_o/out_ready_i | step_level_o, dir_level_o, finished_o, running_o
// cfg      | cfg_we_i (no wait)      | cfg_wdata_i = wave_half_steps
//
// One transaction per clock sustained while out_ready_i stays high; a result passes
// from an accepted transaction through the input register, then the result register.
// Motor state advances when the input register hands its transaction to the
// result register, so each tick or start is one pass of compare/increment logic.
// Reset puts the unit in the power-on wave with wave_half_steps = 200.
// With out_ready_i low the result holds and the input register takes one more
// transaction before in_ready_o drops.
module stepper_step_pulse_sequencer #(
  parameter int unsigned STEP_COUNT_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sps_pkg::WaveW-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          kind_i,
  input  logic [sps_pkg::SpeedW-1:0]    speed_i,
  input  logic [sps_pkg::StepCntW-1:0]  step_count_i,
  input  logic                          continuous_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          step_level_o,
  output logic                          dir_level_o,
  output logic [1:0]                    finished_o,
  output logic                          running_o
);

  sps_pkg::item_t   in_item;
  sps_pkg::item_t   held_item;
  sps_pkg::result_t core_result;
  sps_pkg::result_t out_result;
  logic             held_valid;
  logic             advance;

  always_comb begin
    in_item.kind       = sps_pkg::kind_e'(kind_i);
    in_item.speed      = speed_i;
    in_item.step_count = step_count_i;
    in_item.continuous = continuous_i;
  end

  // Advance when the input register holds a transaction and the result register is free or drains this cycle.
  assign advance = held_valid && (!out_valid_o || out_ready_i);

  sps_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .item_i  (in_item),
    .take_i  (advance),
    .valid_o (held_valid),
    .item_o  (held_item)
  );

  sps_core #(
    .CntW (STEP_COUNT_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (held_item),
    .advance_i   (advance),
    .result_o    (core_result)
  );

  sps_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance),
    .result_i (core_result),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .result_o (out_result)
  );

  assign step_level_o = out_result.step_level;
  assign dir_level_o  = out_result.dir_level;
  assign finished_o   = out_result.finished;
  assign running_o    = out_result.running;

endmodule

// ===== hdl/sps_checker.sv =====
module sps_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       step_level_o,
  input logic       dir_level_o,
  input logic [1:0] finished_o,
  input logic       running_o
);

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(step_level_o) &&
      $stable(dir_level_o) && $stable(finished_o) && $stable(running_o))
    else $error("stalled result changed");

  // Input side only blocks when the result register is full and stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input blocked without output stall");

  // Any finish report means the unit stopped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && finished_o != sps_pkg::FIN_NONE |-> !running_o)
    else $error("finish reported while running");

  // The wave ends only in its second half, with dir high.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && finished_o == sps_pkg::FIN_BOOT |-> dir_level_o)
    else $error("boot done with dir low");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> finished_o == sps_pkg::FIN_NONE ||
      finished_o == sps_pkg::FIN_BOOT || finished_o == sps_pkg::FIN_MOVE)
    else $error("illegal finish code");

endmodule

bind stepper_step_pulse_sequencer sps_checker u_sps_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .step_level_o (step_level_o),
  .dir_level_o  (dir_level_o),
  .finished_o   (finished_o),
  .running_o    (running_o)
);

// ===== tb/stepper_step_pulse_sequencer_tb.sv =====
`timescale 1ns / 100ps

module stepper_step_pulse_sequencer_tb;

  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 4;

  logic                          clk        = 1'b0;
  logic                          rst_n      = 1'b0;
  logic                          cfg_we     = 1'b0;
  logic [sps_pkg::WaveW-1:0]     cfg_wdata  = '0;
  logic                          in_valid   = 1'b0;
  logic                          in_ready;
  logic                          kind       = 1'b0;
  logic [sps_pkg::SpeedW-1:0]    speed      = '0;
  logic [sps_pkg::StepCntW-1:0]  step_count = '0;
  logic                          continuous = 1'b0;
  logic                          out_valid;
  logic                          out_ready  = 1'b0;
  logic                          step_level;
  logic                          dir_level;
  logic [1:0]                    finished;
  logic                          running;

  int unsigned send_idle_pct = 31;
  int unsigned recv_idle_pct = 60;
  int unsigned stall_cnt     = 0;
  int          err_cnt       = 0;

  sps_pkg::result_t expected_q[$];

  // Motor state as the block should hold it
  logic                         wave_on    = 1'b1;
  logic                         motor_on   = 1'b1;
  logic                         step_q     = 1'b0;
  logic                         dir_q      = 1'b0;
  logic [sps_pkg::StepCntW-1:0] toggle_cnt = '0;
  logic [sps_pkg::SpeedW-1:0]   div_cnt    = '0;
  logic [sps_pkg::SpeedW-1:0]   speed_q    = '0;
  logic [sps_pkg::StepCntW-1:0] target_q   = '0;
  logic                         cont_q     = 1'b0;
  logic [sps_pkg::WaveW-1:0]    half_steps = sps_pkg::WaveHalfStepsRst;

  stepper_step_pulse_sequencer i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .kind_i       (kind),
    .speed_i      (speed),
    .step_count_i (step_count),
    .continuous_i (continuous),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .step_level_o (step_level),
    .dir_level_o  (dir_level),
    .finished_o   (finished),
    .running_o    (running)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Advance the motor state by one transaction and return the line levels after it
  function automatic sps_pkg::result_t predict_motor(input sps_pkg::item_t it);
    sps_pkg::result_t res;
    sps_pkg::fin_e    fin;
    fin = sps_pkg::FIN_NONE;
    if (it.kind == sps_pkg::KIND_START) begin
      speed_q  = it.speed;
      target_q = it.step_count;
      cont_q   = it.continuous;
      motor_on = 1'b1;
    end else if (motor_on) begin
      if (wave_on) begin
        step_q     = ~step_q;
        toggle_cnt = toggle_cnt + 16'd1;
        if (toggle_cnt == half_steps[sps_pkg::StepCntW-1:0]) begin
          toggle_cnt = '0;
          if (!dir_q) begin
            dir_q = 1'b1;
          end else begin
            wave_on  = 1'b0;
            motor_on = 1'b0;
            speed_q  = 8'd1;
            fin      = sps_pkg::FIN_BOOT;
          end
        end
      end else if (speed_q == '0) begin
        motor_on = 1'b0;
      end else begin
        div_cnt = div_cnt + 8'd1;
        if (div_cnt == speed_q) begin
          div_cnt = '0;
          step_q  = ~step_q;
          if (!cont_q) begin
            toggle_cnt = toggle_cnt + 16'd1;
            if (toggle_cnt == target_q) begin
              toggle_cnt = '0;
              motor_on   = 1'b0;
              fin        = sps_pkg::FIN_MOVE;
            end
          end
        end
      end
    end
    res.step_level = step_q;
    res.dir_level  = dir_q;
    res.finished   = fin;
    res.running    = motor_on;
    return res;
  endfunction

  function automatic sps_pkg::item_t tick_item();
    sps_pkg::item_t it;
    it.kind       = sps_pkg::KIND_TICK;
    it.speed      = 8'($urandom);
    it.step_count = 16'($urandom);
    it.continuous = 1'($urandom);
    return it;
  endfunction

  function automatic sps_pkg::item_t start_item(input logic [sps_pkg::SpeedW-1:0] spd,
                                                input logic [sps_pkg::StepCntW-1:0] cnt,
                                                input logic cont);
    sps_pkg::item_t it;
    it.kind       = sps_pkg::KIND_START;
    it.speed      = spd;
    it.step_count = cnt;
    it.continuous = cont;
    return it;
  endfunction

  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic send_item(input sps_pkg::item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= it.kind;
    speed      <= it.speed;
    step_count <= it.step_count;
    continuous <= it.continuous;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(predict_motor(it));
  endtask

  // Drop valid and wait until every pending result has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_wave_half(input logic [sps_pkg::WaveW-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    half_steps  = value;
  endtask

  task automatic test_boot_wave();
    write_wave_half(16'hFFFF);
    // start during the wave is stored but the wave keeps going
    send_item(start_item(8'($urandom), 16'($urandom), 1'($urandom)));
    repeat (5) send_item(tick_item());
    write_wave_half(16'd8);
    while (!dir_q) send_item(tick_item());
    write_wave_half(16'd1);
    send_item(tick_item());
    send_item(tick_item());
  endtask

  task automatic test_directed_moves();
    // counted move to completion, then a tick while stopped
    send_item(start_item(8'd1, 16'd2, 1'b0));
    repeat (3) send_item(tick_item());
    // target zero: counter keeps going past every small value
    send_item(start_item(8'd1, 16'd0, 1'b0));
    repeat (3) send_item(tick_item());
    // restart while running, target below the count already reached
    send_item(start_item(8'd3, 16'd2, 1'b0));
    repeat (2) send_item(tick_item());
    // speed below divider: divider wraps before it matches
    send_item(start_item(8'd1, 16'hFFFF, 1'b1));
    repeat (2) send_item(tick_item());
    // speed zero stops on the next tick
    send_item(start_item(8'd0, 16'hFFFF, 1'b1));
    repeat (2) send_item(tick_item());
    send_item(start_item(8'd255, 16'hFFFF, 1'b0));
    repeat (2) send_item(tick_item());
    // finish a short move so the toggle counter starts clean
    send_item(start_item(8'd1, toggle_cnt + 16'd1, 1'b0));
    while (motor_on) send_item(tick_item());
  endtask

  task automatic test_random_moves(input int n_items);
    int             sent;
    int             cap;
    sps_pkg::item_t it;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 75) begin
        // target relative to the live counter so that most moves can finish
        send_item(start_item(
          ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'($urandom_range(1, 4)),
          ($urandom_range(0, 9) == 0) ? 16'($urandom) : toggle_cnt + 16'($urandom_range(1, 5)),
          1'($urandom_range(0, 4) == 0)));
        sent++;
        cap = $urandom_range(8, 60);
        while (motor_on && cap > 0) begin
          send_item(tick_item());
          sent++;
          cap--;
        end
        repeat ($urandom_range(0, 2)) begin
          send_item(tick_item());
          sent++;
        end
      end else begin
        it            = tick_item();
        it.kind       = $urandom_range(0, 1) ? sps_pkg::KIND_START : sps_pkg::KIND_TICK;
        it.speed      = ($urandom_range(0, 3) == 0) ? '0 : 8'($urandom);
        send_item(it);
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_result
    sps_pkg::result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        flag_error("result with no transaction pending");
      end else begin
        exp_r = expected_q.pop_front();
        if (step_level !== exp_r.step_level)
          flag_error($sformatf("step_level got %0b exp %0b", step_level, exp_r.step_level));
        if (dir_level !== exp_r.dir_level)
          flag_error($sformatf("dir_level got %0b exp %0b", dir_level, exp_r.dir_level));
        if (finished !== exp_r.finished)
          flag_error($sformatf("finished got %0d exp %0d", finished, exp_r.finished));
        if (running !== exp_r.running)
          flag_error($sformatf("running got %0b exp %0b", running, exp_r.running));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
  end

  initial begin : watchdog
    wait (stall_cnt >= StallLimit);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_boot_wave();
    test_directed_moves();
    test_random_moves(200);
    write_wave_half(16'hFFFF);
    send_idle_pct = 60;
    recv_idle_pct = 31;
    test_random_moves(200);
    write_wave_half(16'($urandom_range(1, 65535)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_moves(200);
    drain_results();
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
